### hdl/bhfk_pkg.sv
// ----------------------------------------------------------------------------
// bhfk_pkg
// Types, constants and arithmetic helpers shared by the forward kinematics
// block and its multiplier unit.
// ----------------------------------------------------------------------------
package bhfk_pkg;

   localparam int FK_MAX_BONES = 256;
   localparam int MAT_WORDS    = 12;

   typedef enum logic [7:0] {
      S_IDLE = 8'b0000_0001,
      S_Q    = 8'b0000_0010,
      S_QW   = 8'b0000_0100,
      S_L    = 8'b0000_1000,
      S_LW   = 8'b0001_0000,
      S_M    = 8'b0010_0000,
      S_MW   = 8'b0100_0000,
      S_OUT  = 8'b1000_0000
   } state_type;

   typedef enum logic [2:0] {
      PH_Q = 3'b001,
      PH_L = 3'b010,
      PH_M = 3'b100
   } phase_type;

   typedef struct packed {
      phase_type  phase;
      logic [1:0] r;
      logic [1:0] c;
      logic [1:0] k;
      logic [3:0] qi;
   } tag_type;

   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      logic signed [31:0] res;
      if (v > 64'sd2147483647) begin
         res = 32'sh7FFF_FFFF;
      end else if (v < -64'sd2147483648) begin
         res = 32'sh8000_0000;
      end else begin
         res = v[31:0];
      end
      return res;
   endfunction

endpackage

### hdl/bhfk_ram.sv
// ----------------------------------------------------------------------------
// bhfk_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module bhfk_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 3072
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### hdl/bhfk_mul.sv
// ----------------------------------------------------------------------------
// bhfk_mul
// Shared signed 32x32 multiplier with a registered product and a tag that
// travels alongside it.
// ----------------------------------------------------------------------------
module bhfk_mul
   import bhfk_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                in_vld,
   input  tag_type             in_tag,
   input  logic signed [31:0]  a,
   input  logic signed [31:0]  b,
   output logic                out_vld,
   output tag_type             out_tag,
   output logic signed [63:0]  prod
);

   logic               vld_ff;
   tag_type            tag_ff;
   logic signed [63:0] prod_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= in_vld;
      end
      tag_ff  <= in_tag;
      prod_ff <= a * b;
   end

   assign out_vld = vld_ff;
   assign out_tag = tag_ff;
   assign prod    = prod_ff;

endmodule

### hdl/bone_hierarchy_forward_kinematics.sv
// ----------------------------------------------------------------------------
// bone_hierarchy_forward_kinematics
// Builds each bone's local TRS matrix, multiplies it by the stored global
// matrix of its parent and stores and emits the three affine rows.
// ----------------------------------------------------------------------------
// Only one bone is in flight at a time: a new request is taken only in the
// idle state, after the last row of the previous bone was taken. The single
// shared 32x32 multiplier runs 9 + 9 + 48 products per bone, and each of the
// three phases is followed by a wait until the multiplier pipeline drains.
// Reset clears the control state only; the matrix store holds undefined
// contents until written and has no clearing pass.
module bone_hierarchy_forward_kinematics
   import bhfk_pkg::*;
#(
   parameter int MAX_BONES = FK_MAX_BONES
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // bone_index[7:0], parent_index[16:8], trans_x/y/z[112:17],
   // quat_w/x/y/z[176:113], scale_x/y/z[272:177], zero fill
   input  logic [279:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // out_bone[7:0], row_number[9:8], col_zero[41:10], col_one[73:42],
   // col_two[105:74], col_trans[137:106], zero fill
   output logic [143:0] rsp_tdata,
   output logic         rsp_tlast
);

   localparam int DEPTH = MAT_WORDS * MAX_BONES;
   localparam int AW    = $clog2(DEPTH);

   state_type state_ff, state_in;
   logic [1:0] r_ff, r_in, c_ff, c_in, k_ff, k_in, orow_ff, orow_in;
   logic [3:0] qi_ff, qi_in;

   logic [7:0]          bone_ff;
   logic                has_par_ff, store_ff;
   logic [AW-1:0]       base_ff, wbase_ff;
   logic signed [31:0]  tr_ff [3];
   logic signed [15:0]  qt_ff [4];
   logic signed [31:0]  sc_ff [3];
   logic signed [31:0]  qp_ff [9];
   logic signed [31:0]  r16_ff [3][3];
   logic signed [31:0]  lm_ff [3][3];
   logic signed [31:0]  gm_ff [3][4];
   logic signed [49:0]  acc_hi_ff;
   logic [18:0]         acc_lo_ff;

   logic    iss_vld_ff, iss_vld;
   tag_type iss_tag_ff, iss_tag;

   logic               mul_vld;
   tag_type            mul_tag;
   logic signed [63:0] mul_prod;
   logic signed [31:0] op_a, op_b;
   logic [31:0]        ram_rd;
   logic [AW-1:0]      rd_addr, wr_addr;
   logic               wr_en;

   logic               req_fire, drained;
   logic [7:0]         in_bone;
   logic signed [8:0]  in_par;
   logic signed [35:0] rot [9];
   logic signed [35:0] xx, yy, zz, xy, xz, yz, wx, wy, wz;
   logic [1:0]         qa, qb;

   logic signed [49:0] term_hi, hi_sum, total;
   logic [18:0]        term_lo, lo_sum;

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign in_bone    = req_tdata[7:0];
   assign in_par     = req_tdata[16:8];
   assign drained    = !iss_vld_ff && !mul_vld;

   always_comb begin
      state_in = state_ff;
      r_in     = r_ff;
      c_in     = c_ff;
      k_in     = k_ff;
      qi_in    = qi_ff;
      orow_in  = orow_ff;
      iss_vld  = 1'b0;
      iss_tag  = '{phase: PH_Q, r: r_ff, c: c_ff, k: k_ff, qi: qi_ff};
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               state_in = S_Q;
               qi_in    = '0;
            end
         end
         S_Q: begin
            iss_vld = 1'b1;
            qi_in   = qi_ff + 4'd1;
            if (qi_ff == 4'd8) begin
               state_in = S_QW;
            end
         end
         S_QW: begin
            if (drained) begin
               state_in = S_L;
               r_in     = '0;
               c_in     = '0;
            end
         end
         S_L: begin
            iss_vld       = 1'b1;
            iss_tag.phase = PH_L;
            if (c_ff == 2'd2) begin
               c_in = '0;
               r_in = r_ff + 2'd1;
               if (r_ff == 2'd2) begin
                  state_in = S_LW;
               end
            end else begin
               c_in = c_ff + 2'd1;
            end
         end
         S_LW: begin
            if (drained) begin
               state_in = S_M;
               r_in     = '0;
               c_in     = '0;
               k_in     = '0;
            end
         end
         S_M: begin
            iss_vld       = 1'b1;
            iss_tag.phase = PH_M;
            k_in          = k_ff + 2'd1;
            if (k_ff == 2'd3) begin
               c_in = c_ff + 2'd1;
               if (c_ff == 2'd3) begin
                  r_in = r_ff + 2'd1;
                  if (r_ff == 2'd2) begin
                     state_in = S_MW;
                  end
               end
            end
         end
         S_MW: begin
            if (drained) begin
               state_in = S_OUT;
               orow_in  = '0;
            end
         end
         S_OUT: begin
            if (rsp_tready) begin
               orow_in = orow_ff + 2'd1;
               if (orow_ff == 2'd2) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         iss_vld_ff <= 1'b0;
         r_ff       <= '0;
         c_ff       <= '0;
         k_ff       <= '0;
         qi_ff      <= '0;
         orow_ff    <= '0;
      end else begin
         state_ff   <= state_in;
         iss_vld_ff <= iss_vld;
         r_ff       <= r_in;
         c_ff       <= c_in;
         k_ff       <= k_in;
         qi_ff      <= qi_in;
         orow_ff    <= orow_in;
      end
      iss_tag_ff <= iss_tag;
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         bone_ff    <= in_bone;
         has_par_ff <= !in_par[8] && (in_par[7:0] < in_bone)
                       && (32'(in_par[7:0]) < MAX_BONES);
         store_ff   <= 32'(in_bone) < MAX_BONES;
         base_ff    <= AW'(32'(in_par[7:0]) * MAT_WORDS);
         wbase_ff   <= AW'(32'(in_bone) * MAT_WORDS);
         tr_ff[0]   <= req_tdata[48:17];
         tr_ff[1]   <= req_tdata[80:49];
         tr_ff[2]   <= req_tdata[112:81];
         qt_ff[0]   <= req_tdata[128:113];
         qt_ff[1]   <= req_tdata[144:129];
         qt_ff[2]   <= req_tdata[160:145];
         qt_ff[3]   <= req_tdata[176:161];
         sc_ff[0]   <= req_tdata[208:177];
         sc_ff[1]   <= req_tdata[240:209];
         sc_ff[2]   <= req_tdata[272:241];
      end
   end

   // Quaternion products in the order xx, yy, zz, xy, xz, yz, wx, wy, wz.
   always_comb begin
      case (iss_tag_ff.qi)
         4'd0:    begin qa = 2'd1; qb = 2'd1; end
         4'd1:    begin qa = 2'd2; qb = 2'd2; end
         4'd2:    begin qa = 2'd3; qb = 2'd3; end
         4'd3:    begin qa = 2'd1; qb = 2'd2; end
         4'd4:    begin qa = 2'd1; qb = 2'd3; end
         4'd5:    begin qa = 2'd2; qb = 2'd3; end
         4'd6:    begin qa = 2'd0; qb = 2'd1; end
         4'd7:    begin qa = 2'd0; qb = 2'd2; end
         default: begin qa = 2'd0; qb = 2'd3; end
      endcase
   end

   // A root bone multiplies by the identity, which leaves the local matrix
   // unchanged through the same rounding path.
   always_comb begin
      op_a = '0;
      op_b = '0;
      case (iss_tag_ff.phase)
         PH_Q: begin
            op_a = 32'(qt_ff[qa]);
            op_b = 32'(qt_ff[qb]);
         end
         PH_L: begin
            op_a = r16_ff[iss_tag_ff.r][iss_tag_ff.c];
            op_b = sc_ff[iss_tag_ff.c];
         end
         PH_M: begin
            if (has_par_ff) begin
               op_a = $signed(ram_rd);
            end else if (iss_tag_ff.k == iss_tag_ff.r) begin
               op_a = 32'sd65536;
            end
            if (iss_tag_ff.k != 2'd3) begin
               if (iss_tag_ff.c == 2'd3) begin
                  op_b = tr_ff[iss_tag_ff.k];
               end else begin
                  op_b = lm_ff[iss_tag_ff.k][iss_tag_ff.c];
               end
            end else if (iss_tag_ff.c == 2'd3) begin
               op_b = 32'sd65536;
            end
         end
         default: begin
            op_a = '0;
         end
      endcase
   end

   assign rd_addr = base_ff + AW'({r_ff, k_ff});

   bhfk_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .in_vld  (iss_vld_ff),
      .in_tag  (iss_tag_ff),
      .a       (op_a),
      .b       (op_b),
      .out_vld (mul_vld),
      .out_tag (mul_tag),
      .prod    (mul_prod)
   );

   always_comb begin
      xx = 36'(qp_ff[0]);
      yy = 36'(qp_ff[1]);
      zz = 36'(qp_ff[2]);
      xy = 36'(qp_ff[3]);
      xz = 36'(qp_ff[4]);
      yz = 36'(qp_ff[5]);
      wx = 36'(qp_ff[6]);
      wy = 36'(qp_ff[7]);
      wz = 36'(qp_ff[8]);
      rot[0] = 36'sd268435456 - ((yy + zz) <<< 1);
      rot[1] = (xy - wz) <<< 1;
      rot[2] = (xz + wy) <<< 1;
      rot[3] = (xy + wz) <<< 1;
      rot[4] = 36'sd268435456 - ((xx + zz) <<< 1);
      rot[5] = (yz - wx) <<< 1;
      rot[6] = (xz - wy) <<< 1;
      rot[7] = (yz + wx) <<< 1;
      rot[8] = 36'sd268435456 - ((xx + yy) <<< 1);
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_QW && drained) begin
         for (int i = 0; i < 9; i++) begin
            r16_ff[i / 3][i % 3] <= 32'((rot[i] + 36'sd2048) >>> 12);
         end
      end
   end

   assign term_hi = 50'(mul_prod >>> 16);
   assign term_lo = 19'(mul_prod[15:0]);
   assign hi_sum  = acc_hi_ff + term_hi;
   assign lo_sum  = acc_lo_ff + term_lo;
   assign total   = hi_sum + 50'((lo_sum + 19'd32768) >> 16);

   always_ff @(posedge clock) begin
      if (mul_vld) begin
         case (mul_tag.phase)
            PH_Q: begin
               qp_ff[mul_tag.qi] <= mul_prod[31:0];
            end
            PH_L: begin
               lm_ff[mul_tag.r][mul_tag.c] <= sat32((mul_prod + 64'sd32768) >>> 16);
            end
            PH_M: begin
               if (mul_tag.k == 2'd0) begin
                  acc_hi_ff <= term_hi;
                  acc_lo_ff <= term_lo;
               end else begin
                  acc_hi_ff <= hi_sum;
                  acc_lo_ff <= lo_sum;
               end
               if (mul_tag.k == 2'd3) begin
                  gm_ff[mul_tag.r][mul_tag.c] <= sat32(64'(total));
               end
            end
            default: begin
               acc_lo_ff <= acc_lo_ff;
            end
         endcase
      end
   end

   assign wr_en   = mul_vld && (mul_tag.phase == PH_M) && (mul_tag.k == 2'd3) && store_ff;
   assign wr_addr = wbase_ff + AW'({mul_tag.r, mul_tag.c});

   bhfk_ram #(
      .WIDTH (32),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (32'(sat32(64'(total)))),
      .rd_addr (rd_addr),
      .rd_data (ram_rd)
   );

   assign rsp_tvalid = (state_ff == S_OUT);
   assign rsp_tlast  = (orow_ff == 2'd2);
   assign rsp_tdata  = {6'd0, gm_ff[orow_ff][3], gm_ff[orow_ff][2], gm_ff[orow_ff][1],
                        gm_ff[orow_ff][0], orow_ff, bone_ff};

endmodule

### hdl/bhfk_checker.sv
// ----------------------------------------------------------------------------
// bhfk_checker
// Port-level checks of the forward kinematics block, bound to its top level.
// ----------------------------------------------------------------------------
module bhfk_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [143:0] rsp_tdata,
   input logic         rsp_tlast
);

   // A bone is taken only while no other bone is in flight.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input accepted while a bone is in flight");

   a_last_is_row_two: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tlast == (rsp_tdata[9:8] == 2'd2)))
      else $error("last flag does not match row two");

   a_row_advance: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast |=>
         rsp_tvalid && (rsp_tdata[9:8] == $past(rsp_tdata[9:8]) + 2'd1)
         && (rsp_tdata[7:0] == $past(rsp_tdata[7:0])))
      else $error("rows of one bone not emitted in order");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result transaction changed");

endmodule

bind bone_hierarchy_forward_kinematics bhfk_checker u_bhfk_checker (.*);

### verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Forward kinematics testbench
// Sends bone poses over the request stream and checks every emitted affine
// row against a local computation of T*R(q)*S chained through parent matrices.
// Every valid parent (non-negative and below the bone's own index) is a bone
// that was already stored, so no undefined store entry is ever read.
// ----------------------------------------------------------------------------
module testbench
   import bhfk_pkg::*;
();

   typedef struct {
      logic [7:0]         bone;
      logic signed [8:0]  parent;
      logic signed [31:0] trans [3];
      logic signed [15:0] quat  [4];
      logic signed [31:0] scale [3];
   } pose_type;

   typedef struct {
      logic [7:0]  bone;
      logic [1:0]  row;
      logic [31:0] col [4];
      logic        last;
   } row_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [279:0] req_tdata = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [143:0] rsp_tdata;
   logic         rsp_tlast;

   row_type     rows_due [$];
   logic [31:0] matrix_copy [FK_MAX_BONES][12];
   bit          stored [FK_MAX_BONES];
   int          errors = 0;
   int          idle_cycles = 0;
   bit          quiet = 1'b0;
   logic        hold_start = 1'b0;
   int          hold_cnt = 0;
   int          stall_cnt = 0;

   bone_hierarchy_forward_kinematics u_top (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast)
   );

   always #6 clock = ~clock;

   function automatic longint round_sh(longint x, int n);
      return (x + (64'sd1 <<< (n - 1))) >>> n;
   endfunction

   function automatic longint sat(longint x);
      if (x > 64'sd2147483647) return 64'sd2147483647;
      if (x < -64'sd2147483648) return -64'sd2147483648;
      return x;
   endfunction

   function automatic void compute_global(pose_type p);
      longint w, x, y, z, one, r16, hi, prod;
      longint rot [3][3];
      longint loc [3][4];
      longint par [3][4];
      longint glob [3][4];
      longint lo;
      row_type rw;
      bit     linked;
      w = p.quat[0]; x = p.quat[1]; y = p.quat[2]; z = p.quat[3];
      one = 64'sd1 <<< 28;
      rot[0][0] = one - 2 * (y * y + z * z);
      rot[0][1] = 2 * (x * y - w * z);
      rot[0][2] = 2 * (x * z + w * y);
      rot[1][0] = 2 * (x * y + w * z);
      rot[1][1] = one - 2 * (x * x + z * z);
      rot[1][2] = 2 * (y * z - w * x);
      rot[2][0] = 2 * (x * z - w * y);
      rot[2][1] = 2 * (y * z + w * x);
      rot[2][2] = one - 2 * (x * x + y * y);
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            r16 = round_sh(rot[r][c], 12);
            loc[r][c] = sat(round_sh(r16 * longint'(p.scale[c]), 16));
         end
         loc[r][3] = p.trans[r];
      end
      linked = p.parent >= 0 && int'(p.parent) < int'(p.bone);
      if (linked) begin
         for (int r = 0; r < 3; r++)
            for (int c = 0; c < 4; c++)
               par[r][c] = longint'($signed(matrix_copy[p.parent][r * 4 + c]));
         for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 4; c++) begin
               hi = 0;
               lo = 0;
               for (int k = 0; k < 3; k++) begin
                  prod = par[r][k] * loc[k][c];
                  hi += prod >>> 16;
                  lo += prod & 64'hFFFF;
               end
               if (c == 3) hi += par[r][3];
               glob[r][c] = sat(hi + ((lo + 64'h8000) >>> 16));
            end
         end
      end else begin
         glob = loc;
      end
      for (int r = 0; r < 3; r++) begin
         rw.bone = p.bone;
         rw.row  = r[1:0];
         for (int c = 0; c < 4; c++) begin
            rw.col[c] = glob[r][c][31:0];
            matrix_copy[p.bone][r * 4 + c] = glob[r][c][31:0];
         end
         rw.last = (r == 2);
         rows_due.push_back(rw);
      end
      stored[p.bone] = 1'b1;
   endfunction

   task automatic send_pose(pose_type p);
      int gap;
      req_tdata <= {7'b0, p.scale[2], p.scale[1], p.scale[0],
                    p.quat[3], p.quat[2], p.quat[1], p.quat[0],
                    p.trans[2], p.trans[1], p.trans[0], p.parent, p.bone};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      compute_global(p);
      gap = 0;
      if (!quiet && $urandom_range(0, 3) == 0)
         gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 3);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   function automatic logic signed [31:0] rand_q16();
      case ($urandom_range(0, 3))
         0: return 32'sd65536 + $signed($urandom_range(0, 8192)) - 32'sd4096;
         1: return $signed($urandom_range(0, 2097152)) - 32'sd1048576;
         2: return $signed($urandom_range(0, 33554432)) - 32'sd16777216;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic signed [15:0] rand_quat();
      return 16'($signed($urandom_range(0, 32768)) - 32'sd16384);
   endfunction

   function automatic pose_type rand_pose(logic [7:0] bone);
      pose_type p;
      int    cand;
      p.bone = bone;
      for (int i = 0; i < 3; i++) begin
         p.trans[i] = rand_q16();
         p.scale[i] = rand_q16();
      end
      for (int i = 0; i < 4; i++) p.quat[i] = rand_quat();
      p.parent = -9'sd1;
      case ($urandom_range(0, 9))
         0: p.parent = -$signed({1'b0, 8'($urandom_range(1, 255))});
         1: p.parent = $signed({1'b0, 8'($urandom_range(bone, 255))});
         2: ;
         default: begin
            for (int t = 0; t < 8 && bone > 0; t++) begin
               cand = $urandom_range(0, bone - 1);
               if (stored[cand]) begin
                  p.parent = 9'(cand);
                  break;
               end
            end
         end
      endcase
      return p;
   endfunction

   function automatic pose_type unit_pose(logic [7:0] bone, logic signed [8:0] parent);
      pose_type p;
      p.bone = bone;
      p.parent = parent;
      for (int i = 0; i < 3; i++) begin
         p.trans[i] = 32'sd65536 * (i + 1);
         p.scale[i] = 32'sd65536;
      end
      p.quat[0] = 16'sd16384;
      p.quat[1] = 0; p.quat[2] = 0; p.quat[3] = 0;
      return p;
   endfunction

   task automatic wait_drained();
      while (rows_due.size() != 0) @(posedge clock);
   endtask

   task automatic test_extreme_roots();
      pose_type p;
      send_pose(unit_pose(8'd0, -9'sd1));
      p = unit_pose(8'd1, -9'sd256);
      p.trans[0] = 32'h7FFF_FFFF; p.trans[1] = 32'h8000_0000; p.trans[2] = 0;
      p.scale[0] = 32'h7FFF_FFFF; p.scale[1] = 32'h8000_0000; p.scale[2] = 32'hFFFF_FFFF;
      send_pose(p);
      p.bone = 8'd2;
      p.quat[0] = -16'sd16384; p.quat[1] = 16'sd16384;
      p.quat[2] = -16'sd16384; p.quat[3] = 16'sd16384;
      send_pose(p);
      p.bone = 8'd3;
      for (int i = 0; i < 4; i++) p.quat[i] = 0;
      p.scale[0] = 0; p.scale[1] = 32'sd1; p.scale[2] = -32'sd1;
      send_pose(p);
      p = unit_pose(8'd255, -9'sd1);
      p.quat[1] = 16'sd11585; p.quat[0] = 16'sd11585;
      send_pose(p);
   endtask

   task automatic test_chain();
      pose_type p;
      send_pose(unit_pose(8'd10, -9'sd1));
      for (int b = 11; b < 15; b++) begin
         p = unit_pose(b[7:0], 9'(b - 1));
         p.quat[0] = 16'sd15137; p.quat[3] = 16'sd6270;
         p.scale[b % 3] = 32'sd131072;
         send_pose(p);
      end
      p = unit_pose(8'd20, 9'sd1);
      send_pose(p);
      p = unit_pose(8'd254, 9'sd2);
      p.trans[0] = 32'h7FFF_0000;
      send_pose(p);
      send_pose(unit_pose(8'd255, 9'sd254));
      send_pose(unit_pose(8'd10, 9'sd3));
   endtask

   task automatic test_invalid_parent();
      send_pose(unit_pose(8'd30, 9'sd30));
      send_pose(unit_pose(8'd31, 9'sd255));
      send_pose(unit_pose(8'd0, 9'sd0));
      send_pose(unit_pose(8'd40, 9'sd100));
      send_pose(unit_pose(8'd41, -9'sd77));
   endtask

   task automatic test_backpressure();
      @(posedge clock);
      hold_start <= 1'b1;
      @(posedge clock);
      hold_start <= 1'b0;
      for (int i = 0; i < 30; i++) send_pose(rand_pose($urandom_range(0, 255)));
   endtask

   task automatic test_drain_pause();
      req_tvalid <= 1'b0;
      wait_drained();
      @(posedge clock);
      for (int i = 0; i < 10; i++) send_pose(rand_pose($urandom_range(0, 255)));
   endtask

   task automatic test_random();
      quiet = 1'b1;
      for (int i = 0; i < 80; i++) send_pose(rand_pose($urandom_range(0, 255)));
      quiet = 1'b0;
      for (int i = 0; i < 360; i++) send_pose(rand_pose($urandom_range(0, 255)));
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_start) begin
         hold_cnt <= 1500;
         rsp_tready <= 1'b0;
      end else if (hold_cnt > 0) begin
         hold_cnt <= hold_cnt - 1;
         rsp_tready <= 1'b0;
      end else if (stall_cnt > 0) begin
         stall_cnt <= stall_cnt - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
         if (!quiet && $urandom_range(0, 3) == 0)
            stall_cnt <= ($urandom_range(0, 9) == 0) ? $urandom_range(20, 80)
                                                    : $urandom_range(1, 3);
      end
   end

   always @(posedge clock) begin
      row_type want;
      row_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.bone = rsp_tdata[7:0];
         got.row  = rsp_tdata[9:8];
         for (int c = 0; c < 4; c++) got.col[c] = rsp_tdata[10 + 32 * c +: 32];
         got.last = rsp_tlast;
         if (rows_due.size() == 0) begin
            $display("%0t: unexpected row bone %0d row %0d", $time, got.bone, got.row);
            errors++;
         end else begin
            want = rows_due.pop_front();
            if (got.bone !== want.bone) begin
               $display("%0t: bone expected %0d actual %0d", $time, want.bone, got.bone);
               errors++;
            end
            if (got.row !== want.row) begin
               $display("%0t: row expected %0d actual %0d", $time, want.row, got.row);
               errors++;
            end
            for (int c = 0; c < 4; c++)
               if (got.col[c] !== want.col[c]) begin
                  $display("%0t: bone %0d row %0d col %0d expected %h actual %h",
                           $time, want.bone, want.row, c, want.col[c], got.col[c]);
                  errors++;
               end
            if (got.last !== want.last) begin
               $display("%0t: tlast expected %b actual %b", $time, want.last, got.last);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || reset) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= 5000) begin
         $display("testbench NOT OK");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_extreme_roots();
      test_chain();
      test_invalid_parent();
      test_backpressure();
      test_drain_pause();
      test_random();
      req_tvalid <= 1'b0;
      wait_drained();
      repeat (200) @(posedge clock);
      if (errors == 0 && rows_due.size() == 0) begin
         $display("testbench OK");
      end else begin
         $display("testbench NOT OK");
      end
      $finish;
   end

endmodule
